// File: src/ekd_pkg.sv
// ekd_pkg: shared types and constants for the eager key debouncer
// holds transaction payload structs, lane status struct and field widths
// no dependencies

package ekd_pkg;

    // fixed field widths
    localparam int KEY_W   = 5;
    localparam int TIME_W  = 16;
    localparam int DEB_W   = 8;
    localparam int CNT_W   = 3;

    // defaults
    localparam int NUM_KEYS_DEF = 5;
    localparam logic [DEB_W-1:0] DEBOUNCE_RST = 8'd5;

    // input transaction: one scan
    typedef struct packed {
        logic [KEY_W-1:0]  pressed_now;
        logic [TIME_W-1:0] now_ms;
    } t_in_item;

    // output transaction: debounced view after the scan
    typedef struct packed {
        logic [KEY_W-1:0] keys_down;
        logic             all_settled;
        logic [CNT_W-1:0] down_count;
    } t_out_item;

    // per-key state after the scan, from a lane to the merge stage
    typedef struct packed {
        logic stable;
        logic settling;
    } t_lane_stat;

endpackage

// File: src/eager_key_debouncer.sv
// eager_key_debouncer: top level, per-key lanes, merge stage and output buffer
// uses ekd_pkg, ekd_lane, ekd_merge and ekd_out_buf
// a result is formed in its scan's accept cycle and registered in the output register, or in the skid entry if stalled
// throughput: one scan per cycle while the input is not stalled; every lane updates its key in the accept cycle
// a two-entry output buffer lets one more scan in while a result is stalled
// reset (synchronous, active low): all keys up, none settling, timers zero,
// debounce setting 5 ms, output buffer empty

module eager_key_debouncer #(
    parameter int NUM_KEYS = ekd_pkg::NUM_KEYS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  ekd_pkg::t_in_item          i_in_data,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output ekd_pkg::t_out_item         o_out_data,
    input  logic                       i_cfg_we,
    input  logic [ekd_pkg::DEB_W-1:0]  i_cfg_wdata
);

    // keys beyond the scan width never change, so they get no lane
    localparam int LANES = (NUM_KEYS < ekd_pkg::KEY_W) ? NUM_KEYS : ekd_pkg::KEY_W;

    logic [ekd_pkg::DEB_W-1:0] r_debounce_ms;
    logic                      in_acc;
    ekd_pkg::t_lane_stat       lane_stat [LANES];
    ekd_pkg::t_out_item        res;

    // debounce setting register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_ms <= ekd_pkg::DEBOUNCE_RST;
        end else if (i_cfg_we) begin
            r_debounce_ms <= i_cfg_wdata;
        end
    end

    assign in_acc = i_in_valid && !o_in_stall;

    // one lane per key
    for (genvar k = 0; k < LANES; k++) begin : g_lane
        ekd_lane u_lane (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_en          (in_acc),
            .i_raw         (i_in_data.pressed_now[k]),
            .i_now_ms      (i_in_data.now_ms),
            .i_debounce_ms (r_debounce_ms),
            .o_stat        (lane_stat[k])
        );
    end

    // combine lane states
    ekd_merge #(
        .LANES (LANES)
    ) u_merge (
        .i_stat (lane_stat),
        .o_res  (res)
    );

    // result buffering
    ekd_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_data  (res),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_data  (o_out_data)
    );

endmodule

// File: src/ekd_lane.sv
// ekd_lane: debounce state and update logic for one key
// uses ekd_pkg for field widths and the lane status struct

module ekd_lane (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_raw,
    input  logic [ekd_pkg::TIME_W-1:0]  i_now_ms,
    input  logic [ekd_pkg::DEB_W-1:0]   i_debounce_ms,
    output ekd_pkg::t_lane_stat         o_stat
);

    logic                       r_stable;
    logic                       r_prev;
    logic                       r_settling;
    logic [ekd_pkg::TIME_W-1:0] r_start;

    logic                       n_stable;
    logic                       n_settling;
    logic                       restart;
    logic [ekd_pkg::TIME_W-1:0] elapsed;
    logic                       timeout;
    logic                       settling_a;
    logic                       stable_a;

    // timeout phase: wrapping elapsed time against the settle setting
    assign elapsed    = i_now_ms - r_start;
    assign timeout    = r_settling && (elapsed > {{(ekd_pkg::TIME_W - ekd_pkg::DEB_W){1'b0}},
                                                  i_debounce_ms});
    assign settling_a = r_settling && !timeout;
    assign stable_a   = (timeout && !i_raw) ? 1'b0 : r_stable;

    // change phase: eager press, anything else restarts the settle timer
    always_comb begin
        n_stable   = stable_a;
        n_settling = settling_a;
        restart    = 1'b0;
        if (i_raw != r_prev) begin
            if (!settling_a && i_raw) begin
                n_stable = 1'b1;
            end else begin
                n_settling = 1'b1;
                restart    = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stable   <= 1'b0;
            r_prev     <= 1'b0;
            r_settling <= 1'b0;
        end else if (i_en) begin
            r_stable   <= n_stable;
            r_prev     <= i_raw;
            r_settling <= n_settling;
        end
    end

    // settle start time, reset to zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= '0;
        end else if (i_en && restart) begin
            r_start <= i_now_ms;
        end
    end

    assign o_stat.stable   = n_stable;
    assign o_stat.settling = n_settling;

endmodule

// File: src/ekd_merge.sv
// ekd_merge: combines the lane states into one output transaction
// uses ekd_pkg for the lane status and output payload structs

module ekd_merge #(
    parameter int LANES = ekd_pkg::NUM_KEYS_DEF
) (
    input  ekd_pkg::t_lane_stat i_stat [LANES],
    output ekd_pkg::t_out_item  o_res
);

    logic [ekd_pkg::KEY_W-1:0] mask;
    logic                      any_settling;
    logic [ekd_pkg::CNT_W-1:0] cnt;

    // gather mask, settling flag and popcount over the lanes
    always_comb begin
        mask         = '0;
        any_settling = 1'b0;
        cnt          = '0;
        for (int k = 0; k < LANES; k++) begin
            mask[k]      = i_stat[k].stable;
            any_settling = any_settling | i_stat[k].settling;
            cnt          = cnt + ekd_pkg::CNT_W'(i_stat[k].stable);
        end
    end

    assign o_res.keys_down   = mask;
    assign o_res.all_settled = !any_settling;
    assign o_res.down_count  = cnt;

endmodule

// File: src/ekd_out_buf.sv
// ekd_out_buf: output register with a skid stage for result transactions
// uses ekd_pkg for the output payload struct

module ekd_out_buf (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  ekd_pkg::t_out_item i_data,
    output logic               o_valid,
    input  logic               i_stall,
    output ekd_pkg::t_out_item o_data
);

    logic               r_out_valid;
    logic               r_skid_valid;
    ekd_pkg::t_out_item r_out_data;
    ekd_pkg::t_out_item r_skid_data;

    logic in_acc;
    logic out_fire;

    assign in_acc   = i_valid && !r_skid_valid;
    assign out_fire = r_out_valid && !i_stall;

    // valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_fire) begin
                r_skid_valid <= 1'b0;
            end
        end else if (in_acc) begin
            if (r_out_valid && !out_fire) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end else if (out_fire) begin
            r_out_valid <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_fire) begin
                r_out_data <= r_skid_data;
            end
        end else if (in_acc) begin
            if (r_out_valid && !out_fire) begin
                r_skid_data <= i_data;
            end else begin
                r_out_data <= i_data;
            end
        end
    end

    assign o_stall = r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;

    // skid entry only ever holds the younger of two results
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid stage full while output register empty");

    // a transaction arriving at a stalled full output lands in the skid stage
    a_skid_catch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && r_out_valid && i_stall) |=> r_skid_valid)
        else $error("transaction lost at stalled output");

    // a drained skid stage refills the output register
    a_skid_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && out_fire) |=> (r_out_valid && !r_skid_valid))
        else $error("skid stage did not drain into output register");

    // reset empties both stages
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!r_out_valid && !r_skid_valid))
        else $error("buffer not empty after reset");

endmodule
